@@ design/apt2d_pkg.sv @@
package apt2d_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_SCALE_X     = 3'd0;
    localparam logic [2:0] REG_SCALE_Y     = 3'd1;
    localparam logic [2:0] REG_ROT_ANGLE   = 3'd2;
    localparam logic [2:0] REG_TRANSLATE_X = 3'd3;
    localparam logic [2:0] REG_TRANSLATE_Y = 3'd4;
    localparam logic [2:0] REG_CENTER_X    = 3'd5;
    localparam logic [2:0] REG_CENTER_Y    = 3'd6;

    // 2*pi in Q3.28 and 1.0 in Q1.31.
    localparam logic [30:0] TWO_PI_Q28 = 31'h6487_ED51;
    localparam logic [31:0] ONE_Q31    = 32'h8000_0000;

    // Half of a quadrant in angle units.
    localparam logic [13:0] HALF_QUADRANT = 14'h2000;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_X,
        SEQ_X2,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_SIN,
        SEQ_COEF
    } t_seq_state;

    // Series divisors k are applied as a reciprocal multiply. For a dividend n below
    // 2^31, n / k equals (n * m) >> s with s = 31 + ceil(log2 k) and
    // m = floor(2^s / k) + 1. sel = 0 for sine (four terms), 1 for cosine (five terms).
    function automatic logic [31:0] series_recip(input logic sel, input logic [2:0] step);
        logic [31:0] m;
        m = 32'((64'd1 << 32) / 64'd2 + 64'd1);
        if (!sel) begin
            case (step)
                3'd0:    m = 32'((64'd1 << 38) / 64'd72 + 64'd1);
                3'd1:    m = 32'((64'd1 << 37) / 64'd42 + 64'd1);
                3'd2:    m = 32'((64'd1 << 36) / 64'd20 + 64'd1);
                default: m = 32'((64'd1 << 34) / 64'd6 + 64'd1);
            endcase
        end else begin
            case (step)
                3'd0:    m = 32'((64'd1 << 38) / 64'd90 + 64'd1);
                3'd1:    m = 32'((64'd1 << 37) / 64'd56 + 64'd1);
                3'd2:    m = 32'((64'd1 << 36) / 64'd30 + 64'd1);
                3'd3:    m = 32'((64'd1 << 35) / 64'd12 + 64'd1);
                default: m = 32'((64'd1 << 32) / 64'd2 + 64'd1);
            endcase
        end
        return m;
    endfunction

    function automatic logic [5:0] series_shift(input logic sel, input logic [2:0] step);
        logic [5:0] s;
        s = 6'd32;
        if (!sel) begin
            case (step)
                3'd0:    s = 6'd38;
                3'd1:    s = 6'd37;
                3'd2:    s = 6'd36;
                default: s = 6'd34;
            endcase
        end else begin
            case (step)
                3'd0:    s = 6'd38;
                3'd1:    s = 6'd37;
                3'd2:    s = 6'd36;
                3'd3:    s = 6'd35;
                default: s = 6'd32;
            endcase
        end
        return s;
    endfunction

endpackage

@@ design/affine_point_transform_2d.sv @@
// 2D affine point transform: out = M * (P - C) + T + C, where M is the
// rotation matrix scaled per output axis.
// Input: a point is taken at a rising edge with i_start high and o_busy low.
// One point may enter in every cycle while o_busy is low. Output: o_valid
// goes high for exactly one cycle together with o_out_x, o_out_y and
// o_saturated; results come in request order and the receiver cannot
// stall them, so the pipeline never holds.
// o_saturated is high when either coordinate was clamped.
// Configuration: a write on i_cfg_valid/o_cfg_ready sets one register;
// indexes above six are ignored. Every write to a register starts a rebuild
// of the matrix coefficients, during which o_busy is high; the rebuild has
// two steps for the angle, two per series term (a multiply, then a
// reciprocal multiply for the constant divisor) over nine terms, one for the
// sine product and four for the coefficients. Configuration writes are taken
// at any time; a new write restarts the rebuild.
// Reset: scales 1.0, all other registers 0, identity matrix, no rebuild,
// pipeline empty.
module affine_point_transform_2d #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    localparam int DW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;
    localparam int DH = DW - 32;
    localparam int SW = DW + 34;

    // Configuration registers.
    logic signed [31:0] r_scale_x, r_scale_y, r_trans_x, r_trans_y, r_cent_x, r_cent_y;
    logic [15:0]        r_angle;
    logic signed [32:0] r_off_x, r_off_y;

    // Coefficient sequencer.
    apt2d_pkg::t_seq_state r_state, n_state;
    logic [31:0] r_x, n_x, r_x2, n_x2, r_t, n_t, r_sn, n_sn, r_dvd, n_dvd;
    logic        r_poly, n_poly;
    logic [2:0]  r_step, n_step;
    logic [1:0]  r_idx, n_idx;
    logic signed [31:0] r_mat [4];
    logic signed [31:0] n_coef;
    logic        n_coef_we;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic [13:0] ang_f;
    logic [14:0] ang_r;
    logic [31:0] div_m;
    logic [5:0]  div_s;
    logic [67:0] div_q;
    logic [31:0] quot;
    logic [31:0] sn_u, cs_u;
    logic signed [33:0] trig_c, trig_s, trig;
    logic signed [31:0] coef_scale;
    logic        cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && (i_cfg_index <= apt2d_pkg::REG_CENTER_Y);
    assign o_busy      = (r_state != apt2d_pkg::SEQ_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= 32'(64'd1 << FRACTION_BITS);
            r_scale_y <= 32'(64'd1 << FRACTION_BITS);
            r_angle   <= '0;
            r_trans_x <= '0;
            r_trans_y <= '0;
            r_cent_x  <= '0;
            r_cent_y  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                apt2d_pkg::REG_SCALE_X:     r_scale_x <= i_cfg_data;
                apt2d_pkg::REG_SCALE_Y:     r_scale_y <= i_cfg_data;
                apt2d_pkg::REG_ROT_ANGLE:   r_angle   <= i_cfg_data[15:0];
                apt2d_pkg::REG_TRANSLATE_X: r_trans_x <= i_cfg_data;
                apt2d_pkg::REG_TRANSLATE_Y: r_trans_y <= i_cfg_data;
                apt2d_pkg::REG_CENTER_X:    r_cent_x  <= i_cfg_data;
                apt2d_pkg::REG_CENTER_Y:    r_cent_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output offsets only change with configuration, so they are kept ready.
    always_ff @(posedge i_clk) begin
        r_off_x <= 33'(r_trans_x) + 33'(r_cent_x);
        r_off_y <= 33'(r_trans_y) + 33'(r_cent_y);
    end

    // Angle folded into the first half quadrant.
    assign ang_f = r_angle[13:0];
    assign ang_r = (ang_f <= apt2d_pkg::HALF_QUADRANT) ? {1'b0, ang_f}
                                                       : 15'h4000 - {1'b0, ang_f};

    assign div_m = apt2d_pkg::series_recip(r_poly, r_step);
    assign div_s = apt2d_pkg::series_shift(r_poly, r_step);
    assign div_q = mul_p >> div_s;
    assign quot  = div_q[31:0];

    // At coefficient time r_t holds the cosine series and r_sn the sine.
    assign sn_u = (ang_f > apt2d_pkg::HALF_QUADRANT) ? r_t : r_sn;
    assign cs_u = (ang_f > apt2d_pkg::HALF_QUADRANT) ? r_sn : r_t;

    always_comb begin
        trig_c = '0;
        trig_s = '0;
        case (r_angle[15:14])
            2'd0: begin
                trig_c = $signed({2'b00, cs_u});
                trig_s = $signed({2'b00, sn_u});
            end
            2'd1: begin
                trig_c = -$signed({2'b00, sn_u});
                trig_s = $signed({2'b00, cs_u});
            end
            2'd2: begin
                trig_c = -$signed({2'b00, cs_u});
                trig_s = -$signed({2'b00, sn_u});
            end
            default: begin
                trig_c = $signed({2'b00, sn_u});
                trig_s = -$signed({2'b00, cs_u});
            end
        endcase
        case (r_idx)
            2'd0:    trig = trig_c;
            2'd1:    trig = -trig_s;
            2'd2:    trig = trig_s;
            default: trig = trig_c;
        endcase
        coef_scale = r_idx[1] ? r_scale_y : r_scale_x;
    end

    // Shared multiplier of the sequencer.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            apt2d_pkg::SEQ_X: begin
                mul_a = $signed({19'd0, ang_r});
                mul_b = $signed({3'd0, apt2d_pkg::TWO_PI_Q28});
            end
            apt2d_pkg::SEQ_X2: begin
                mul_a = $signed({2'b00, r_x});
                mul_b = $signed({2'b00, r_x});
            end
            apt2d_pkg::SEQ_MUL: begin
                mul_a = $signed({2'b00, r_x2});
                mul_b = $signed({2'b00, r_t});
            end
            apt2d_pkg::SEQ_DIV: begin
                mul_a = $signed({2'b00, r_dvd});
                mul_b = $signed({2'b00, div_m});
            end
            apt2d_pkg::SEQ_SIN: begin
                mul_a = $signed({2'b00, r_x});
                mul_b = $signed({2'b00, r_t});
            end
            apt2d_pkg::SEQ_COEF: begin
                mul_a = 34'(coef_scale);
                mul_b = trig;
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_x2      = r_x2;
        n_t       = r_t;
        n_sn      = r_sn;
        n_poly    = r_poly;
        n_step    = r_step;
        n_dvd     = r_dvd;
        n_idx     = r_idx;
        n_coef    = mul_p[62:31];
        n_coef_we = 1'b0;
        unique case (r_state)
            apt2d_pkg::SEQ_IDLE: ;
            apt2d_pkg::SEQ_X: begin
                n_x     = mul_p[44:13];
                n_state = apt2d_pkg::SEQ_X2;
            end
            apt2d_pkg::SEQ_X2: begin
                n_x2    = mul_p[62:31];
                n_t     = apt2d_pkg::ONE_Q31;
                n_poly  = 1'b0;
                n_step  = '0;
                n_state = apt2d_pkg::SEQ_MUL;
            end
            apt2d_pkg::SEQ_MUL: begin
                n_dvd   = mul_p[62:31];
                n_state = apt2d_pkg::SEQ_DIV;
            end
            apt2d_pkg::SEQ_DIV: begin
                n_t = apt2d_pkg::ONE_Q31 - quot;
                if (!r_poly && r_step == 3'd3) begin
                    n_state = apt2d_pkg::SEQ_SIN;
                end else if (r_poly && r_step == 3'd4) begin
                    n_idx   = '0;
                    n_state = apt2d_pkg::SEQ_COEF;
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = apt2d_pkg::SEQ_MUL;
                end
            end
            apt2d_pkg::SEQ_SIN: begin
                n_sn    = mul_p[62:31];
                n_t     = apt2d_pkg::ONE_Q31;
                n_poly  = 1'b1;
                n_step  = '0;
                n_state = apt2d_pkg::SEQ_MUL;
            end
            apt2d_pkg::SEQ_COEF: begin
                n_coef_we = 1'b1;
                // Clamp when the product does not fit 32 bits after the shift.
                if (!((&mul_p[67:62]) || !(|mul_p[67:62]))) begin
                    n_coef = mul_p[67] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                n_idx = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    n_state = apt2d_pkg::SEQ_IDLE;
                end
            end
            default: n_state = apt2d_pkg::SEQ_IDLE;
        endcase
        if (cfg_we) begin
            n_state = apt2d_pkg::SEQ_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apt2d_pkg::SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_x2   <= n_x2;
        r_t    <= n_t;
        r_sn   <= n_sn;
        r_poly <= n_poly;
        r_step <= n_step;
        r_dvd  <= n_dvd;
        r_idx  <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[0] <= 32'(64'd1 << FRACTION_BITS);
            r_mat[1] <= '0;
            r_mat[2] <= '0;
            r_mat[3] <= 32'(64'd1 << FRACTION_BITS);
        end else if (n_coef_we) begin
            r_mat[r_idx] <= n_coef;
        end
    end

    // Point pipeline.
    logic              r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [DW-1:0]     r1_dx, r1_dy;
    logic signed [64:0]       r2_pl_xa, r2_pl_xb, r2_pl_ya, r2_pl_yb;
    logic signed [31+DH:0]    r2_ph_xa, r2_ph_xb, r2_ph_ya, r2_ph_yb;
    logic signed [65:0]       r3_lo_x, r3_lo_y;
    logic signed [32+DH:0]    r3_hi_x, r3_hi_y;
    logic signed [SW-1:0]     r4_s_x, r4_s_y;
    logic signed [SW-1:0]     r5_v_x, r5_v_y;
    logic signed [SW-1:0]     sh_x, sh_y;
    logic                     sat_x, sat_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_start && !o_busy;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            o_valid <= r_v5;
        end
    end

    assign sh_x  = r4_s_x >>> FRACTION_BITS;
    assign sh_y  = r4_s_y >>> FRACTION_BITS;
    assign sat_x = !((&r5_v_x[SW-1:COORD_WIDTH-1]) || !(|r5_v_x[SW-1:COORD_WIDTH-1]));
    assign sat_y = !((&r5_v_y[SW-1:COORD_WIDTH-1]) || !(|r5_v_y[SW-1:COORD_WIDTH-1]));

    always_ff @(posedge i_clk) begin
        // Stage 1: offset from the pivot.
        r1_dx <= DW'(i_point_x) - DW'(r_cent_x);
        r1_dy <= DW'(i_point_y) - DW'(r_cent_y);
        // Stage 2: partial products on the low 32 bits and the high part.
        r2_pl_xa <= r_mat[0] * $signed({1'b0, r1_dx[31:0]});
        r2_pl_xb <= r_mat[1] * $signed({1'b0, r1_dy[31:0]});
        r2_pl_ya <= r_mat[2] * $signed({1'b0, r1_dx[31:0]});
        r2_pl_yb <= r_mat[3] * $signed({1'b0, r1_dy[31:0]});
        r2_ph_xa <= r_mat[0] * $signed(r1_dx[DW-1:32]);
        r2_ph_xb <= r_mat[1] * $signed(r1_dy[DW-1:32]);
        r2_ph_ya <= r_mat[2] * $signed(r1_dx[DW-1:32]);
        r2_ph_yb <= r_mat[3] * $signed(r1_dy[DW-1:32]);
        // Stage 3: sum each half.
        r3_lo_x <= 66'(r2_pl_xa) + 66'(r2_pl_xb);
        r3_lo_y <= 66'(r2_pl_ya) + 66'(r2_pl_yb);
        r3_hi_x <= (33+DH)'(r2_ph_xa) + (33+DH)'(r2_ph_xb);
        r3_hi_y <= (33+DH)'(r2_ph_ya) + (33+DH)'(r2_ph_yb);
        // Stage 4: the exact dot product.
        r4_s_x <= (SW'(r3_hi_x) <<< 32) + SW'(r3_lo_x);
        r4_s_y <= (SW'(r3_hi_y) <<< 32) + SW'(r3_lo_y);
        // Stage 5: drop fraction bits (floor) and add translation plus pivot.
        r5_v_x <= sh_x + SW'(r_off_x);
        r5_v_y <= sh_y + SW'(r_off_y);
        // Stage 6: saturate to the coordinate width.
        if (sat_x) begin
            o_out_x <= r5_v_x[SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                    : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else begin
            o_out_x <= r5_v_x[COORD_WIDTH-1:0];
        end
        if (sat_y) begin
            o_out_y <= r5_v_y[SW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                    : {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else begin
            o_out_y <= r5_v_y[COORD_WIDTH-1:0];
        end
        o_saturated <= sat_x || sat_y;
    end

endmodule
